### rtl/core/nmtt_pkg.sv
// Shared types, constants and helpers for the nearest mask threshold table.
`default_nettype none

package nmtt_pkg;

	localparam int MAX_SETS_DEF = 32;
	localparam int GATE_COUNT_DEF = 32;
	localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_LOOKUP     = 3'd0,
		MODE_SAVE_CLEAN = 3'd1,
		MODE_SAVE_DIRTY = 3'd2,
		MODE_REMOVE     = 3'd3,
		MODE_CLEAR      = 3'd4
	} mode_t;

	typedef enum logic {
		CFG_CLEAN_DEFAULT = 1'b0,
		CFG_DIRTY_DEFAULT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] gate_mask;
		logic [15:0] limit_value;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] current_mask;
		logic [15:0] clean_limit;
		logic [15:0] dirty_limit;
		logic [5:0]  entry_count;
	} out_item_t;

	// One table entry as it is kept in memory.
	typedef struct packed {
		logic [31:0] mask;
		logic [15:0] clean;
		logic [15:0] dirty;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic rd_en;
	} scan_ctl_t;

	typedef struct packed {
		logic pend;
		logic found;
		logic free;
		logic kill;
	} scan_stat_t;

	function automatic logic [5:0] pc32(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 6'({2'b00, v[4*i]} + {2'b00, v[4*i+1]} + {2'b00, v[4*i+2]}
				+ {2'b00, v[4*i+3]});
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### rtl/core/nmtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module nmtt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/nmtt_scan.sv
// Two-stage entry evaluator that walks the table and keeps the best candidate.
`default_nettype none

module nmtt_scan
	import nmtt_pkg::*;
#(
	parameter int MAX_SETS = MAX_SETS_DEF,
	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scan_ctl_t           ctl,
	input  wire logic [SW-1:0]       rd_idx,
	input  wire mode_t               mode,
	input  wire logic [31:0]         key,
	input  wire logic [5:0]          want,
	input  wire logic [MAX_SETS-1:0] slot_valid,
	input  wire entry_t              rdata,
	output scan_stat_t               stat,
	output logic [SW-1:0]            best_idx,
	output entry_t                   best_ent,
	output logic [SW-1:0]            free_idx,
	output logic [SW-1:0]            kill_idx
);

	logic          en_s1;
	logic [SW-1:0] idx_s1;

	logic          en_s2;
	logic          vld_s2;
	logic [SW-1:0] idx_s2;
	entry_t        ent_s2;
	logic [5:0]    have_s2;
	logic [5:0]    com_s2;
	logic          eq_s2;
	logic          hit_s2;

	logic          found_q;
	logic          free_q;
	logic [5:0]    best_dist_q;
	logic [5:0]    best_com_q;

	logic [5:0]    spread;
	logic          take_near;
	logic          take;

	// First stage: the read data for idx_s1 is on rdata now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
		end else begin
			en_s1 <= ctl.rd_en;
			en_s2 <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx;
		vld_s2  <= slot_valid[idx_s1];
		idx_s2  <= idx_s1;
		ent_s2  <= rdata;
		have_s2 <= pc32(rdata.mask);
		com_s2  <= pc32(rdata.mask & key);
		eq_s2   <= (rdata.mask == key);
		hit_s2  <= ((rdata.mask & key) != 32'd0);
	end

	// Second stage: decide by mode whether the entry replaces the best one so far.
	always_comb begin
		spread = (have_s2 > want) ? (have_s2 - want) : (want - have_s2);
		if (!found_q || spread < best_dist_q) begin
			take_near = 1'b1;
		end else if (spread > best_dist_q) begin
			take_near = 1'b0;
		end else if (com_s2 != best_com_q) begin
			take_near = com_s2 > best_com_q;
		end else begin
			take_near = ent_s2.mask < best_ent.mask;
		end

		take = 1'b0;
		unique case (mode) inside
			MODE_LOOKUP: take = take_near;
			MODE_SAVE_CLEAN, MODE_SAVE_DIRTY: take = eq_s2 && !found_q;
			MODE_REMOVE: take = !hit_s2 && (!found_q || ent_s2.mask > best_ent.mask);
			default: take = 1'b0;
		endcase
		take = take && en_s2 && vld_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			if (take) begin
				found_q <= 1'b1;
			end
			if (en_s2 && !vld_s2) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx    <= idx_s2;
			best_ent    <= ent_s2;
			best_dist_q <= spread;
			best_com_q  <= com_s2;
		end
		if (en_s2 && !vld_s2 && !free_q) begin
			free_idx <= idx_s2;
		end
	end

	always_comb begin
		stat.pend  = en_s1 || en_s2;
		stat.found = found_q;
		stat.free  = free_q;
		stat.kill  = en_s2 && vld_s2 && hit_s2 && (mode == MODE_REMOVE);
		kill_idx   = idx_s2;
	end

endmodule

`default_nettype wire

### rtl/core/nearest_mask_threshold_table.sv
// Top level of the nearest mask threshold table: sequencer, valid bits and defaults.
`default_nettype none

// A command is taken when start is high and busy is low. Lookups, saves with a
// nonzero mask and removes on a nonempty table walk every slot of the table
// memory once, one read per cycle, through a two-stage evaluator, then pass
// through drain, commit, fetch and emit, which sets done. Clear, saves with a
// zero mask, trivial removes and unused mode codes skip the walk to commit.
// done is high for exactly one cycle with the result beat on result; there is
// no back-pressure, so the receiver must take it then. Configuration writes
// load the running clean and dirty defaults directly.
module nearest_mask_threshold_table
	import nmtt_pkg::*;
#(
	parameter int MAX_SETS   = MAX_SETS_DEF,
	parameter int GATE_COUNT = GATE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    item,
	output logic             done,
	output out_item_t        result,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int CW = $clog2(MAX_SETS + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SETS - 1);
	localparam logic [31:0] GATE_BITS = 32'((64'd1 << GATE_COUNT) - 64'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_FETCH,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [SW-1:0]       addr_q;
	logic [MAX_SETS-1:0] slot_valid_q;
	logic [CW-1:0]       cnt_q;
	logic [SW-1:0]       cur_q;
	logic                present_q;
	logic                ok_q;
	logic                scanned_q;
	logic [15:0]         clean_def_q;
	logic [15:0]         dirty_def_q;

	mode_t               mode_q;
	logic [31:0]         key_q;
	logic [15:0]         val_q;
	logic [5:0]          want_q;

	logic                accept;
	logic [31:0]         key_in;
	logic                need_scan;
	logic                is_save;
	logic                is_dirty;
	logic [15:0]         nd_clean;
	logic [15:0]         nd_dirty;
	entry_t              new_ent;
	entry_t              upd_ent;
	logic                have;

	scan_ctl_t           scan_ctl;
	scan_stat_t          stat;
	logic [SW-1:0]       best_idx;
	entry_t              best_ent;
	logic [SW-1:0]       free_idx;
	logic [SW-1:0]       kill_idx;

	logic                ram_we;
	logic [SW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	logic [SW-1:0]       ram_raddr;
	entry_t              ram_rdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign key_in = item.gate_mask & GATE_BITS;

	always_comb begin
		unique case (item.mode) inside
			MODE_LOOKUP: need_scan = 1'b1;
			MODE_SAVE_CLEAN, MODE_SAVE_DIRTY: need_scan = (key_in != 32'd0);
			MODE_REMOVE: need_scan = (key_in != 32'd0) && (cnt_q != '0);
			default: need_scan = 1'b0;
		endcase
	end

	always_comb begin
		is_save  = (mode_q == MODE_SAVE_CLEAN) || (mode_q == MODE_SAVE_DIRTY);
		is_dirty = (mode_q == MODE_SAVE_DIRTY);
		nd_clean = (!is_dirty && val_q < clean_def_q) ? val_q : clean_def_q;
		nd_dirty = (is_dirty && val_q < dirty_def_q) ? val_q : dirty_def_q;

		// A new set takes the current default for the kind it does not save.
		new_ent.mask  = key_q;
		new_ent.clean = is_dirty ? nd_clean : val_q;
		new_ent.dirty = is_dirty ? val_q : nd_dirty;

		upd_ent = best_ent;
		if (is_dirty) begin
			upd_ent.dirty = val_q;
		end else begin
			upd_ent.clean = val_q;
		end

		ram_we    = (state_q == ST_COMMIT) && is_save && (key_q != 32'd0)
			&& (stat.found || stat.free);
		ram_waddr = stat.found ? best_idx : free_idx;
		ram_wdata = stat.found ? upd_ent : new_ent;
		ram_re    = (state_q == ST_SCAN) || (state_q == ST_FETCH);
		ram_raddr = (state_q == ST_SCAN) ? addr_q : cur_q;

		scan_ctl.clr   = accept;
		scan_ctl.rd_en = (state_q == ST_SCAN);

		have = present_q && slot_valid_q[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			slot_valid_q <= '0;
			cnt_q        <= '0;
			cur_q        <= '0;
			present_q    <= 1'b0;
			ok_q         <= 1'b0;
			scanned_q    <= 1'b0;
			clean_def_q  <= LIMIT_RESET;
			dirty_def_q  <= LIMIT_RESET;
			done         <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CLEAN_DEFAULT: clean_def_q <= cfg_wdata;
					CFG_DIRTY_DEFAULT: dirty_def_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (stat.kill) begin
				slot_valid_q[kill_idx] <= 1'b0;
				cnt_q                  <= cnt_q - CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						scanned_q <= need_scan;
						state_q   <= need_scan ? ST_SCAN : ST_COMMIT;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + SW'(1);
					if (addr_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.pend) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_FETCH;
					unique case (mode_q) inside
						MODE_LOOKUP: begin
							ok_q <= stat.found;
							if (stat.found) begin
								cur_q     <= best_idx;
								present_q <= 1'b1;
							end
						end
						MODE_SAVE_CLEAN, MODE_SAVE_DIRTY: begin
							if (key_q == 32'd0) begin
								if (is_dirty) begin
									dirty_def_q <= val_q;
								end else begin
									clean_def_q <= val_q;
								end
								ok_q <= 1'b1;
							end else begin
								clean_def_q <= nd_clean;
								dirty_def_q <= nd_dirty;
								ok_q        <= stat.found || stat.free;
								if (stat.found) begin
									cur_q     <= best_idx;
									present_q <= 1'b1;
								end else if (stat.free) begin
									cur_q                  <= free_idx;
									present_q              <= 1'b1;
									slot_valid_q[free_idx] <= 1'b1;
									cnt_q                  <= cnt_q + CW'(1);
								end
							end
						end
						MODE_REMOVE: begin
							if (scanned_q) begin
								present_q <= stat.found;
								cur_q     <= stat.found ? best_idx : '0;
								ok_q      <= stat.found;
							end else begin
								ok_q <= present_q;
							end
						end
						MODE_CLEAR: begin
							slot_valid_q <= '0;
							cnt_q        <= '0;
							cur_q        <= '0;
							present_q    <= 1'b0;
							ok_q         <= 1'b1;
						end
						default: ok_q <= present_q;
					endcase
				end
				ST_FETCH: state_q <= ST_EMIT;
				ST_EMIT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(item.mode);
			key_q  <= key_in;
			val_q  <= item.limit_value;
			want_q <= pc32(key_in);
		end
		if (state_q == ST_EMIT) begin
			result.ok           <= ok_q;
			result.current_mask <= have ? ram_rdata.mask : 32'd0;
			result.clean_limit  <= have ? ram_rdata.clean : clean_def_q;
			result.dirty_limit  <= have ? ram_rdata.dirty : dirty_def_q;
			result.entry_count  <= 6'(cnt_q);
		end
	end

	nmtt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_SETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	nmtt_scan #(
		.MAX_SETS(MAX_SETS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.rd_idx    (addr_q),
		.mode      (mode_q),
		.key       (key_q),
		.want      (want_q),
		.slot_valid(slot_valid_q),
		.rdata     (ram_rdata),
		.stat      (stat),
		.best_idx  (best_idx),
		.best_ent  (best_ent),
		.free_idx  (free_idx),
		.kill_idx  (kill_idx)
	);

endmodule

`default_nettype wire
